[hdl/mtcg_pkg.sv]
package mtcg_pkg;

  // Default sizing of the converter samples and the braking gain divider.
  localparam int SAMPLE_BITS_DEF    = 10;
  localparam int BRAKE_GAIN_DIV_DEF = 10;

  // Fixed field widths.
  localparam int CUR_W      = 10;
  localparam int LIMIT_W    = 31;
  localparam int TOP_W      = 16;
  localparam int SCALE_W    = 6;
  localparam int CHARGE_W   = 32;
  localparam int COLOUR_W   = 3;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [CUR_W-1:0]   NOMINAL_CURRENT_RST = CUR_W'(620);
  localparam logic [CUR_W-1:0]   TRIP_CURRENT_RST    = CUR_W'(768);
  localparam logic [CUR_W-1:0]   REGEN_CURRENT_RST   = CUR_W'(469);
  localparam logic [LIMIT_W-1:0] CHARGE_LIMIT_RST    = LIMIT_W'(50000);
  localparam logic [TOP_W-1:0]   PWM_TOP_RST         = TOP_W'(3200);
  localparam logic [SCALE_W-1:0] PEDAL_SCALE_RST     = SCALE_W'(3);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_CURRENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_CURRENT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGEN_CURRENT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PEDAL_SCALE     = 3'd5;

  // Control modes.
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BRAKE  = 2'd2;

  // LED colours.
  localparam logic [COLOUR_W-1:0] COL_RED    = 3'd0;
  localparam logic [COLOUR_W-1:0] COL_GREEN  = 3'd1;
  localparam logic [COLOUR_W-1:0] COL_BLUE   = 3'd2;
  localparam logic [COLOUR_W-1:0] COL_PURPLE = 3'd3;

  typedef struct packed {
    logic [CUR_W-1:0]   nominal_current;
    logic [CUR_W-1:0]   trip_current;
    logic [CUR_W-1:0]   regen_current;
    logic [LIMIT_W-1:0] charge_limit;
    logic [TOP_W-1:0]   pwm_top;
    logic [SCALE_W-1:0] pedal_scale;
  } cfg_t;

  // Per-request flags handed from the input stage to the update stage.
  typedef struct packed {
    logic stop;
    logic brake;
    logic charge_up;
    logic over_max;
    logic brake_neg;
  } flags_t;

endpackage

[hdl/motor_throttle_current_guard.sv]
// The input stage registers an accepted request and the update stage takes it
// into the output registers; a low out_ready can hold it between the two.
// Throughput: one request per cycle unless out_ready stalls the output; the
// control state updates from the registered request; that loop sets the rate.
// Reset (rst, synchronous): registers return to their defaults, mode normal,
// charge and duties zero, compare at the default PWM top, LED green.
module motor_throttle_current_guard
  import mtcg_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int BRAKE_GAIN_DIV = BRAKE_GAIN_DIV_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   stop_pressed,
  input  logic                   brake_held,
  input  logic [SAMPLE_BITS-1:0] current_sample,
  input  logic [SAMPLE_BITS-1:0] pedal_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   shutdown,
  output logic [TOP_W-1:0]       pwm_compare,
  output logic [COLOUR_W-1:0]    led_colour,
  output logic [MODE_W-1:0]      ctrl_mode
);

  localparam int CW = (SAMPLE_BITS > CUR_W) ? SAMPLE_BITS : CUR_W;

  cfg_t             cfg;
  flags_t           flags;
  logic             p_valid;
  logic             take;
  logic [CW-1:0]    charge_mag;
  logic [CW-1:0]    brake_step;
  logic [TOP_W-1:0] thr_duty;
  logic [TOP_W-1:0] thr_compare;

  mtcg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mtcg_prep #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .BRAKE_GAIN_DIV (BRAKE_GAIN_DIV),
    .CW             (CW)
  ) u_prep (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stop_pressed   (stop_pressed),
    .brake_held     (brake_held),
    .current_sample (current_sample),
    .pedal_sample   (pedal_sample),
    .take           (take),
    .p_valid        (p_valid),
    .flags          (flags),
    .charge_mag     (charge_mag),
    .brake_step     (brake_step),
    .thr_duty       (thr_duty),
    .thr_compare    (thr_compare)
  );

  mtcg_core #(
    .CW (CW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .p_valid     (p_valid),
    .flags       (flags),
    .charge_mag  (charge_mag),
    .brake_step  (brake_step),
    .thr_duty    (thr_duty),
    .thr_compare (thr_compare),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shutdown    (shutdown),
    .pwm_compare (pwm_compare),
    .led_colour  (led_colour),
    .ctrl_mode   (ctrl_mode)
  );

endmodule

[hdl/mtcg_cfg.sv]
module mtcg_cfg
  import mtcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_current <= NOMINAL_CURRENT_RST;
      cfg.trip_current    <= TRIP_CURRENT_RST;
      cfg.regen_current   <= REGEN_CURRENT_RST;
      cfg.charge_limit    <= CHARGE_LIMIT_RST;
      cfg.pwm_top         <= PWM_TOP_RST;
      cfg.pedal_scale     <= PEDAL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NOMINAL_CURRENT: cfg.nominal_current <= cfg_data[CUR_W-1:0];
        REG_TRIP_CURRENT:    cfg.trip_current    <= cfg_data[CUR_W-1:0];
        REG_REGEN_CURRENT:   cfg.regen_current   <= cfg_data[CUR_W-1:0];
        REG_CHARGE_LIMIT:    cfg.charge_limit    <= cfg_data[LIMIT_W-1:0];
        REG_PWM_TOP:         cfg.pwm_top         <= cfg_data[TOP_W-1:0];
        REG_PEDAL_SCALE:     cfg.pedal_scale     <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/mtcg_prep.sv]
module mtcg_prep
  import mtcg_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int BRAKE_GAIN_DIV = BRAKE_GAIN_DIV_DEF,
  parameter int CW             = (SAMPLE_BITS > CUR_W) ? SAMPLE_BITS : CUR_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   stop_pressed,
  input  logic                   brake_held,
  input  logic [SAMPLE_BITS-1:0] current_sample,
  input  logic [SAMPLE_BITS-1:0] pedal_sample,
  input  logic                   take,
  output logic                   p_valid,
  output flags_t                 flags,
  output logic [CW-1:0]          charge_mag,
  output logic [CW-1:0]          brake_step,
  output logic [TOP_W-1:0]       thr_duty,
  output logic [TOP_W-1:0]       thr_compare
);

  // Throttle product width and the width it is compared at against the top.
  localparam int DW = SAMPLE_BITS + SCALE_W;
  localparam int PW = (DW > TOP_W) ? DW : TOP_W;

  // Division by the gain divider as a multiply by a rounded-up reciprocal;
  // the result is exact for every numerator below 2**CW.
  localparam int L   = $clog2(BRAKE_GAIN_DIV);
  localparam int SH  = CW + L;
  localparam int PRW = SH + CW + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SH) + longint'(BRAKE_GAIN_DIV) - 64'd1) / longint'(BRAKE_GAIN_DIV);
  localparam logic [CW:0] RECIP = RECIP_VAL[CW:0];

  logic [CW-1:0]    cur_ext;
  logic [CW-1:0]    tgt_ext;
  logic [CW-1:0]    bc_ext;
  logic             up;
  logic             neg;
  logic [CW-1:0]    cmag;
  logic [CW-1:0]    bmag;
  logic [PRW-1:0]   prod;
  logic [DW-1:0]    raw;
  logic [PW-1:0]    raw_ext;
  logic [PW-1:0]    top_ext;
  logic [TOP_W-1:0] duty;

  assign in_ready = !p_valid || take;

  always_comb begin
    cur_ext = CW'(current_sample);
    tgt_ext = CW'(cfg.nominal_current);
    bc_ext  = CW'(cfg.regen_current);
    up      = cur_ext >= tgt_ext;
    cmag    = up ? cur_ext - tgt_ext : tgt_ext - cur_ext;
    neg     = cur_ext > bc_ext;
    bmag    = neg ? cur_ext - bc_ext : bc_ext - cur_ext;
    prod    = PRW'(bmag) * PRW'(RECIP);
    raw     = DW'(pedal_sample) * DW'(cfg.pedal_scale);
    raw_ext = PW'(raw);
    top_ext = PW'(cfg.pwm_top);
    duty    = (raw_ext > top_ext) ? cfg.pwm_top : raw_ext[TOP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      flags.stop      <= stop_pressed;
      flags.brake     <= brake_held;
      flags.charge_up <= up;
      flags.over_max  <= cur_ext > CW'(cfg.trip_current);
      flags.brake_neg <= neg;
      charge_mag      <= cmag;
      brake_step      <= prod[SH +: CW];
      thr_duty        <= duty;
      thr_compare     <= cfg.pwm_top - duty;
    end
  end

endmodule

[hdl/mtcg_core.sv]
module mtcg_core
  import mtcg_pkg::*;
#(
  parameter int CW = CUR_W
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                p_valid,
  input  flags_t              flags,
  input  logic [CW-1:0]       charge_mag,
  input  logic [CW-1:0]       brake_step,
  input  logic [TOP_W-1:0]    thr_duty,
  input  logic [TOP_W-1:0]    thr_compare,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                shutdown,
  output logic [TOP_W-1:0]    pwm_compare,
  output logic [COLOUR_W-1:0] led_colour,
  output logic [MODE_W-1:0]   ctrl_mode
);

  localparam int SW = ((CW > TOP_W) ? CW : TOP_W) + 2;

  logic [CHARGE_W-1:0] charge;
  logic [TOP_W-1:0]    throttle_duty;
  logic [TOP_W-1:0]    brake_duty;

  logic [CHARGE_W-1:0] charge_next;
  logic [TOP_W-1:0]    throttle_duty_next;
  logic [TOP_W-1:0]    brake_duty_next;
  logic                shutdown_next;
  logic [TOP_W-1:0]    pwm_compare_next;
  logic [COLOUR_W-1:0] led_colour_next;
  logic [MODE_W-1:0]   ctrl_mode_next;

  logic [CHARGE_W:0]   charge_sum;
  logic [CHARGE_W-1:0] charge_upd;
  logic                trip;
  logic [TOP_W-1:0]    brake_base;
  logic signed [SW-1:0] brake_sum;
  logic [TOP_W-1:0]    brake_upd;
  logic                do_normal;
  logic                do_brake;

  assign take = p_valid && (!out_valid || out_ready);

  always_comb begin
    // Excess charge integrates the distance from the target current,
    // held at zero below and saturated at the top.
    charge_sum = {1'b0, charge} + (CHARGE_W + 1)'(charge_mag);
    if (flags.charge_up) begin
      charge_upd = charge_sum[CHARGE_W] ? '1 : charge_sum[CHARGE_W-1:0];
    end else begin
      charge_upd = (charge > CHARGE_W'(charge_mag)) ? charge - CHARGE_W'(charge_mag) : '0;
    end
    trip = (charge_upd > CHARGE_W'(cfg.charge_limit)) || flags.over_max;

    // Braking starts from the throttle duty on the request that enters it.
    brake_base = (ctrl_mode == MODE_BRAKE) ? brake_duty : throttle_duty;
    if (flags.brake_neg) begin
      brake_sum = $signed(SW'(brake_base)) - $signed(SW'(brake_step));
    end else begin
      brake_sum = $signed(SW'(brake_base)) + $signed(SW'(brake_step));
    end
    if (brake_sum < 0) begin
      brake_upd = '0;
    end else if (brake_sum > $signed(SW'(cfg.pwm_top))) begin
      brake_upd = cfg.pwm_top;
    end else begin
      brake_upd = brake_sum[TOP_W-1:0];
    end

    charge_next        = charge;
    throttle_duty_next = throttle_duty;
    brake_duty_next    = brake_duty;
    shutdown_next      = shutdown;
    pwm_compare_next   = pwm_compare;
    led_colour_next    = led_colour;
    ctrl_mode_next     = ctrl_mode;
    do_normal          = 1'b0;
    do_brake           = 1'b0;

    case (ctrl_mode)
      MODE_STOP: begin
        if (flags.stop || flags.brake) begin
          shutdown_next   = 1'b1;
          led_colour_next = COL_RED;
        end else begin
          do_normal = 1'b1;
        end
      end
      MODE_BRAKE: begin
        if (flags.brake) begin
          do_brake = 1'b1;
        end else begin
          do_normal = 1'b1;
        end
      end
      default: begin
        if (flags.stop) begin
          ctrl_mode_next  = MODE_STOP;
          shutdown_next   = 1'b1;
          led_colour_next = COL_RED;
        end else if (flags.brake) begin
          do_brake = 1'b1;
        end else begin
          do_normal = 1'b1;
        end
      end
    endcase

    if (do_normal) begin
      ctrl_mode_next     = MODE_NORMAL;
      charge_next        = charge_upd;
      shutdown_next      = trip;
      led_colour_next    = trip ? COL_BLUE : COL_GREEN;
      throttle_duty_next = thr_duty;
      pwm_compare_next   = thr_compare;
    end
    if (do_brake) begin
      ctrl_mode_next   = MODE_BRAKE;
      brake_duty_next  = brake_upd;
      led_colour_next  = COL_PURPLE;
      pwm_compare_next = cfg.pwm_top - brake_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      charge        <= '0;
      throttle_duty <= '0;
      brake_duty    <= '0;
      shutdown      <= 1'b0;
      pwm_compare   <= PWM_TOP_RST;
      led_colour    <= COL_GREEN;
      ctrl_mode     <= MODE_NORMAL;
    end else begin
      if (!out_valid || out_ready) begin
        out_valid <= p_valid;
      end
      if (take) begin
        charge        <= charge_next;
        throttle_duty <= throttle_duty_next;
        brake_duty    <= brake_duty_next;
        shutdown      <= shutdown_next;
        pwm_compare   <= pwm_compare_next;
        led_colour    <= led_colour_next;
        ctrl_mode     <= ctrl_mode_next;
      end
    end
  end

endmodule
